// ----- rtl/address_symbol_range_lookup_assert.svh -----
// Assertion macros for the symbol range lookup block.
`ifndef ADDRESS_SYMBOL_RANGE_LOOKUP_ASSERT_SVH
`define ADDRESS_SYMBOL_RANGE_LOOKUP_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Checked on every edge outside reset.
`define ASRL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Checked on every edge, also while reset is asserted.
`define ASRL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define ASRL_ASSERT(lbl, prop, msg)
`define ASRL_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- rtl/asrl_pkg.sv -----
// Types and constants of the symbol range lookup block.
package asrl_pkg;

  localparam int unsigned AddrW  = 32;
  localparam int unsigned SpanW  = 32;
  localparam int unsigned RankW  = 2;
  localparam int unsigned OrderW = 8;
  localparam int unsigned SlotW  = 8;
  localparam int unsigned InDataW  = 80;
  localparam int unsigned OutDataW = 80;

  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_LOAD    = 2'd1,
    OP_RESOLVE = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  // One table entry as stored in memory.
  typedef struct packed {
    logic [OrderW-1:0] name_order;
    logic [RankW-1:0]  type_rank;
    logic [RankW-1:0]  link_rank;
    logic [SpanW-1:0]  span;
    logic [AddrW-1:0]  start;
  } entry_t;

  // One result item, first field in the high bits.
  typedef struct packed {
    logic              table_full;
    logic              at_start;
    logic [RankW-1:0]  type_rank_out;
    logic [RankW-1:0]  link_rank_out;
    logic [AddrW-1:0]  byte_offset;
    logic [AddrW-1:0]  base_addr;
    logic [SlotW-1:0]  entry_slot;
    logic              hit;
  } result_t;

endpackage

// ----- rtl/address_symbol_range_lookup.sv -----
// Address-to-symbol range lookup: entry table in one memory, scanned per resolve.
//
// Holds up to TABLE_DEPTH symbol entries (start, span, link rank, type rank, name
// order) in a single-port-write, registered-read memory. An item with op = clear
// empties the table, op = load appends an entry (dropped and flagged with
// table_full when the table is full), op = resolve looks up a query address.
// Every accepted item gives exactly one result item. Clear and load present
// their result the cycle after they are accepted. A resolve walks the loaded
// entries in slot order, one memory read per cycle, through a read stage, a
// cover check stage and a best-candidate compare stage; from accept to result
// it runs through the scan state, these stages and the done state, and the
// done state waits for the output register to be free. One item is in work
// at a time; a new item is taken while the previous result is still waiting,
// as long as the output register is free or being emptied in that cycle. No
// clearing pass runs after reset: only slots below the entry count are ever
// read.
module address_symbol_range_lookup #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // addr_word[31:0], span_bytes[63:32], link_rank[65:64], type_rank[67:66],
  // name_order[75:68], zero fill [79:76]
  input  logic [asrl_pkg::InDataW-1:0]    s_axis_tdata,
  // op[1:0]
  input  logic [1:0]                      s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // hit[0], entry_slot[8:1], base_addr[40:9], byte_offset[72:41],
  // link_rank_out[74:73], type_rank_out[76:75], at_start[77], table_full[78],
  // zero fill [79]
  output logic [asrl_pkg::OutDataW-1:0]   m_axis_tdata
);

  import asrl_pkg::*;

  localparam int unsigned IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);

  // ---------------------------------------------------------------- input unpack
  op_e    in_op;
  entry_t in_entry;

  assign in_op               = op_e'(s_axis_tuser);
  assign in_entry.start      = s_axis_tdata[31:0];
  assign in_entry.span       = s_axis_tdata[63:32];
  assign in_entry.link_rank  = s_axis_tdata[65:64];
  assign in_entry.type_rank  = s_axis_tdata[67:66];
  assign in_entry.name_order = s_axis_tdata[75:68];

  // ---------------------------------------------------------------- state
  state_e          state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] iss_q, iss_d;      // next slot to read during a scan
  logic [AddrW-1:0] query_q, query_d;

  logic            out_valid_q, out_valid_d;
  result_t         out_q, out_d;

  logic            table_full_w;
  logic            in_fire;
  logic            out_free;

  assign table_full_w = (count_q == CntW'(TABLE_DEPTH));
  assign in_fire      = s_axis_tvalid && s_axis_tready;
  assign out_free     = !out_valid_q || m_axis_tready;

  // ---------------------------------------------------------------- entry memory
  entry_t          mem_q [TABLE_DEPTH];
  entry_t          rd_data_q;
  logic            mem_we;
  logic [IdxW-1:0] mem_raddr;
  logic            rd_issue;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[count_q[IdxW-1:0]] <= in_entry;
    end
    rd_data_q <= mem_q[mem_raddr];
  end

  assign mem_raddr = iss_q[IdxW-1:0];

  // read stage bookkeeping: which slot the registered read data belongs to
  logic            rd_vld_q;
  logic [IdxW-1:0] rd_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= rd_issue;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= mem_raddr;
  end

  // ---------------------------------------------------------------- cover check
  // An entry covers the query when it starts there, or its nonzero span
  // reaches past the offset.
  logic [AddrW-1:0] rd_off;
  logic             rd_covers;

  assign rd_off    = query_q - rd_data_q.start;
  assign rd_covers = (rd_data_q.start <= query_q) &&
                     ((rd_off == '0) ||
                      ((rd_data_q.span != '0) && (rd_off < rd_data_q.span)));

  logic            cand_vld_q;
  entry_t          cand_q;
  logic [IdxW-1:0] cand_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cand_vld_q <= 1'b0;
    end else begin
      cand_vld_q <= rd_vld_q && rd_covers;
    end
  end

  always_ff @(posedge clk_i) begin
    cand_q     <= rd_data_q;
    cand_idx_q <= rd_idx_q;
  end

  // ---------------------------------------------------------------- best compare
  // Slots arrive in ascending order, so a full tie keeps the current best.
  logic            found_q, found_d;
  entry_t          best_q, best_d;
  logic [IdxW-1:0] best_idx_q, best_idx_d;
  logic            cand_beats;
  logic            cand_wins;

  always_comb begin
    if (cand_q.link_rank != best_q.link_rank) begin
      cand_beats = cand_q.link_rank < best_q.link_rank;
    end else if (cand_q.type_rank != best_q.type_rank) begin
      cand_beats = cand_q.type_rank < best_q.type_rank;
    end else if (cand_q.span != best_q.span) begin
      cand_beats = cand_q.span > best_q.span;
    end else begin
      cand_beats = cand_q.name_order < best_q.name_order;
    end
  end

  assign cand_wins = cand_vld_q &&
                     (!found_q || (cand_q.start > best_q.start) ||
                      ((cand_q.start == best_q.start) && cand_beats));

  // ---------------------------------------------------------------- result build
  logic [AddrW-1:0] best_off;
  logic [IdxW+7:0]  best_slot_ext;
  result_t          res_resolve;

  assign best_off      = query_q - best_q.start;
  assign best_slot_ext = {8'd0, best_idx_q};

  always_comb begin
    res_resolve = '0;
    if (found_q) begin
      res_resolve.hit           = 1'b1;
      res_resolve.entry_slot    = best_slot_ext[7:0];
      res_resolve.base_addr     = best_q.start;
      res_resolve.byte_offset   = best_off;
      res_resolve.link_rank_out = best_q.link_rank;
      res_resolve.type_rank_out = best_q.type_rank;
      res_resolve.at_start      = (best_off == '0);
    end
  end

  // ---------------------------------------------------------------- control
  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    iss_d         = iss_q;
    query_d       = query_q;
    found_d       = found_q;
    best_d        = best_q;
    best_idx_d    = best_idx_q;
    out_d         = out_q;
    out_valid_d   = out_valid_q && !m_axis_tready;
    mem_we        = 1'b0;
    rd_issue      = 1'b0;
    s_axis_tready = 1'b0;

    if (cand_wins) begin
      found_d    = 1'b1;
      best_d     = cand_q;
      best_idx_d = cand_idx_q;
    end

    case (state_q)
      ST_IDLE: begin
        s_axis_tready = out_free;
        if (in_fire) begin
          case (in_op)
            OP_CLEAR: begin
              count_d     = '0;
              out_d       = '0;
              out_valid_d = 1'b1;
            end
            OP_LOAD: begin
              out_d       = '0;
              out_valid_d = 1'b1;
              if (table_full_w) begin
                out_d.table_full = 1'b1;
              end else begin
                mem_we  = 1'b1;
                count_d = count_q + CntW'(1);
              end
            end
            OP_RESOLVE: begin
              query_d = in_entry.start;
              iss_d   = '0;
              found_d = 1'b0;
              state_d = ST_SCAN;
            end
            default: begin
              out_d       = '0;
              out_valid_d = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (iss_q < count_q) begin
          rd_issue = 1'b1;
          iss_d    = iss_q + CntW'(1);
        end else if (!rd_vld_q && !cand_vld_q) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_d       = res_resolve;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      iss_q       <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      iss_q       <= iss_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    query_q    <= query_d;
    best_q     <= best_d;
    best_idx_q <= best_idx_d;
    out_q      <= out_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataW - $bits(result_t)){1'b0}}, out_q};

  // ---------------------------------------------------------------- assertions
`include "address_symbol_range_lookup_assert.svh"

  `ASRL_ASSERT(a_count_bound, count_q <= CntW'(TABLE_DEPTH), "entry count past table depth")
  `ASRL_ASSERT(a_busy_no_accept, (state_q != ST_IDLE) |-> !s_axis_tready, "item taken mid-scan")
  `ASRL_ASSERT(a_write_idle, mem_we |-> ((state_q == ST_IDLE) && !table_full_w), "bad table write")
  `ASRL_ASSERT(a_resolve_scans, (in_fire && (in_op == OP_RESOLVE)) |=> (state_q == ST_SCAN), "resolve did not start a scan")

endmodule

// ----- test/address_symbol_range_lookup_tb.sv -----
// Self-checking testbench for the address-to-symbol range lookup block.
module address_symbol_range_lookup_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import asrl_pkg::*;

  localparam int unsigned TABLE_DEPTH = 256;
  // The limit sits well above a full-table resolve plus the longest receiver
  // stall and sender gap.
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  // Cycles to wait after the last result, about one full-table resolve.
  localparam int unsigned DRAIN_CYCLES = 300;
  localparam int unsigned RANDOM_ITEMS = 700;
  localparam int unsigned MAX_REPORTS = 50;
  // The op encoding the block leaves unused.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef enum int {
    RX_OPEN,
    RX_COIN,
    RX_PERIODIC,
    RX_STARVED
  } rx_mode_e;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  // addr_word[31:0], span_bytes[63:32], link_rank[65:64], type_rank[67:66],
  // name_order[75:68], zero fill [79:76]
  logic [InDataW-1:0]  s_axis_tdata = '0;
  // op[1:0]
  logic [1:0]          s_axis_tuser = OP_CLEAR;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // hit[0], entry_slot[8:1], base_addr[40:9], byte_offset[72:41],
  // link_rank_out[74:73], type_rank_out[76:75], at_start[77], table_full[78],
  // zero fill [79]
  logic [OutDataW-1:0] m_axis_tdata;

  // Shadow copy of the symbol table, updated as items are accepted.
  entry_t      sym_table [TABLE_DEPTH];
  int unsigned sym_count = 0;

  // Results owed by the block, oldest first.
  result_t     results_due [$];
  int unsigned mismatch_count = 0;

  int          tx_burst_left = 0;
  rx_mode_e    rx_mode = RX_OPEN;
  int          rx_left = 0;
  int unsigned rx_tick = 0;
  int unsigned quiet_cycles = 0;
  result_t     want;
  result_t     got;

  address_symbol_range_lookup #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Tie break among entries with the same start: lower link rank, lower type
  // rank (3 just ranks after 2), larger span, smaller name order, lower slot.
  function automatic bit outranks(input int unsigned a, input int unsigned b);
    entry_t ea;
    entry_t eb;
    ea = sym_table[a];
    eb = sym_table[b];
    if (ea.link_rank != eb.link_rank) return ea.link_rank < eb.link_rank;
    if (ea.type_rank != eb.type_rank) return ea.type_rank < eb.type_rank;
    if (ea.span != eb.span) return ea.span > eb.span;
    if (ea.name_order != eb.name_order) return ea.name_order < eb.name_order;
    return a < b;
  endfunction

  // Applies one item to the shadow table and returns the result it owes.
  function automatic result_t apply_table_op(input logic [1:0] op,
                                             input logic [31:0] addr,
                                             input logic [31:0] span,
                                             input logic [1:0] lr,
                                             input logic [1:0] tr,
                                             input logic [7:0] no);
    result_t     r;
    bit          found;
    int unsigned best;
    int unsigned i;
    logic [31:0] off;
    r = '0;
    found = 1'b0;
    best = 0;
    case (op)
      OP_CLEAR: sym_count = 0;
      OP_LOAD: begin
        if (sym_count >= TABLE_DEPTH) begin
          r.table_full = 1'b1;
        end else begin
          sym_table[sym_count].start = addr;
          sym_table[sym_count].span = span;
          sym_table[sym_count].link_rank = lr;
          sym_table[sym_count].type_rank = tr;
          sym_table[sym_count].name_order = no;
          sym_count++;
        end
      end
      OP_RESOLVE: begin
        for (i = 0; i < sym_count; i++) begin
          if (sym_table[i].start > addr) continue;
          off = addr - sym_table[i].start;
          // Covered: exact start, or a known span past the offset.
          if (!(off == 0 || (sym_table[i].span != 0 && off < sym_table[i].span))) continue;
          if (!found || sym_table[i].start > sym_table[best].start ||
              (sym_table[i].start == sym_table[best].start && outranks(i, best))) begin
            best = i;
            found = 1'b1;
          end
        end
        if (found) begin
          off = addr - sym_table[best].start;
          r.hit = 1'b1;
          r.entry_slot = 8'(best);
          r.base_addr = sym_table[best].start;
          r.byte_offset = off;
          r.link_rank_out = sym_table[best].link_rank;
          r.type_rank_out = sym_table[best].type_rank;
          r.at_start = (off == 0);
        end
      end
      default: ;  // unused op: no state change, all-zero result
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Checker: predicts on input accept, compares on output accept
  // ---------------------------------------------------------------------------

  task automatic check_field(input string name, input logic [31:0] exp_val,
                             input logic [31:0] act_val);
    if (exp_val !== act_val) begin
      if (mismatch_count < MAX_REPORTS) begin
        $error("%s: expected 0x%0h, actual 0x%0h", name, exp_val, act_val);
      end
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (results_due.size() == 0) begin
        if (mismatch_count < MAX_REPORTS) begin
          $error("result item 0x%0h with none expected", m_axis_tdata);
        end
        mismatch_count++;
      end else begin
        want = results_due.pop_front();
        got = result_t'(m_axis_tdata[$bits(result_t)-1:0]);
        check_field("hit", want.hit, got.hit);
        check_field("entry_slot", want.entry_slot, got.entry_slot);
        check_field("base_addr", want.base_addr, got.base_addr);
        check_field("byte_offset", want.byte_offset, got.byte_offset);
        check_field("link_rank_out", want.link_rank_out, got.link_rank_out);
        check_field("type_rank_out", want.type_rank_out, got.type_rank_out);
        check_field("at_start", want.at_start, got.at_start);
        check_field("table_full", want.table_full, got.table_full);
        check_field("zero_fill", 1'b0, m_axis_tdata[OutDataW-1]);
      end
    end
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      results_due.push_back(apply_table_op(s_axis_tuser, s_axis_tdata[31:0],
                                           s_axis_tdata[63:32], s_axis_tdata[65:64],
                                           s_axis_tdata[67:66], s_axis_tdata[75:68]));
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver back-pressure: phases of random length, each with its own pattern
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = $urandom_range(16, 160);
      rx_tick = 0;
    end
    rx_left--;
    rx_tick++;
    case (rx_mode)
      RX_OPEN:     m_axis_tready <= 1'b1;
      RX_COIN:     m_axis_tready <= 1'($urandom_range(0, 1));
      RX_PERIODIC: m_axis_tready <= (rx_tick % 3) != 0;
      default:     m_axis_tready <= (rx_tick % 24) == 0;  // long stalls
    endcase
  end

  // ---------------------------------------------------------------------------
  // Watchdog: ends the run after too many cycles without any handshake
  // ---------------------------------------------------------------------------

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------

  // Sends one item in bursts with random gaps; returns at the accepting edge
  // with tvalid still high, so back-to-back items need no extra cycle.
  task automatic send_item(input logic [1:0] op, input logic [31:0] addr,
                           input logic [31:0] span, input logic [1:0] lr,
                           input logic [1:0] tr, input logic [7:0] no);
    int gap;
    gap = 0;
    if (tx_burst_left == 0) begin
      tx_burst_left = $urandom_range(1, 16);
      case ($urandom_range(0, 7))
        0, 1, 2: gap = 0;
        7:       gap = $urandom_range(20, 30);
        default: gap = $urandom_range(1, 6);
      endcase
    end
    tx_burst_left--;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'b0, no, tr, lr, span, addr};
    s_axis_tuser <= op;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Holds the sender off until every owed result has arrived.
  task automatic wait_for_results;
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (results_due.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Resolve on an empty table, the unused op and a clear of an empty table.
  task automatic test_empty_table;
    send_item(OP_RESOLVE, 32'h0000_1234, '0, 2'd0, 2'd0, 8'd0);
    send_item(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd3, 2'd3, 8'hFF);
    send_item(OP_CLEAR, '0, '0, 2'd0, 2'd0, 8'd0);
  endtask

  // Cover rules: exact start, inside span, one past span, unknown span,
  // a far entry whose span reaches past a nearer one, address extremes.
  task automatic test_cover_rules;
    send_item(OP_LOAD, 32'h0000_0000, 32'h0000_0000, 2'd0, 2'd0, 8'd0);
    send_item(OP_LOAD, 32'h0000_1000, 32'h0000_0010, 2'd1, 2'd1, 8'd7);
    send_item(OP_LOAD, 32'h0000_2000, 32'h0000_0000, 2'd2, 2'd2, 8'd12);
    send_item(OP_LOAD, 32'h0000_5000, 32'h0010_0000, 2'd0, 2'd1, 8'd40);
    send_item(OP_LOAD, 32'h0000_6000, 32'h0000_0010, 2'd1, 2'd0, 8'd41);
    send_item(OP_LOAD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd3, 2'd3, 8'hFF);
    send_item(OP_RESOLVE, 32'h0000_0000, '0, 2'd0, 2'd0, 8'd0);
    send_item(OP_RESOLVE, 32'h0000_1000, '0, 2'd0, 2'd0, 8'd0);
    send_item(OP_RESOLVE, 32'h0000_100F, '0, 2'd0, 2'd0, 8'd0);
    send_item(OP_RESOLVE, 32'h0000_1010, '0, 2'd0, 2'd0, 8'd0);  // miss
    send_item(OP_RESOLVE, 32'h0000_2001, '0, 2'd0, 2'd0, 8'd0);  // unknown span
    send_item(OP_RESOLVE, 32'h0000_6020, '0, 2'd0, 2'd0, 8'd0);  // via 0x5000
    send_item(OP_RESOLVE, 32'hFFFF_FFFF, '0, 2'd0, 2'd0, 8'd0);
    send_item(OP_RESOLVE, 32'hFFFF_FFFE, '0, 2'd0, 2'd0, 8'd0);
  endtask

  // Same start everywhere: each tie-break rule decides once, type rank 3
  // loses to 1 despite the largest span, and a duplicate goes to the lower slot.
  task automatic test_tie_break;
    send_item(OP_CLEAR, '0, '0, 2'd0, 2'd0, 8'd0);
    send_item(OP_LOAD, 32'h0000_3000, 32'd8, 2'd1, 2'd0, 8'd0);
    send_item(OP_LOAD, 32'h0000_3000, 32'd8, 2'd0, 2'd2, 8'd0);
    send_item(OP_LOAD, 32'h0000_3000, 32'd4, 2'd0, 2'd1, 8'd0);
    send_item(OP_LOAD, 32'h0000_3000, 32'd8, 2'd0, 2'd1, 8'd9);
    send_item(OP_LOAD, 32'h0000_3000, 32'd8, 2'd0, 2'd1, 8'd3);
    send_item(OP_LOAD, 32'h0000_3000, 32'd8, 2'd0, 2'd1, 8'd3);
    send_item(OP_LOAD, 32'h0000_3000, 32'hFFFF_FFFF, 2'd0, 2'd3, 8'd1);
    send_item(OP_RESOLVE, 32'h0000_3000, '0, 2'd0, 2'd0, 8'd0);
    send_item(OP_RESOLVE, 32'h0000_3005, '0, 2'd0, 2'd0, 8'd0);
    send_item(OP_RESOLVE, 32'h0000_3010, '0, 2'd0, 2'd0, 8'd0);
  endtask

  // Fill every slot, then loads are dropped and flagged; resolves scan it all.
  task automatic test_table_full;
    int k;
    send_item(OP_CLEAR, '0, '0, 2'd0, 2'd0, 8'd0);
    for (k = 0; k < TABLE_DEPTH; k++) begin
      send_item(OP_LOAD, 32'h4000_0000 + $urandom_range(0, 4095), $urandom_range(0, 64),
                2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                8'($urandom_range(0, 255)));
    end
    send_item(OP_LOAD, 32'h1234_5678, 32'd16, 2'd0, 2'd0, 8'd0);
    send_item(OP_LOAD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd3, 2'd3, 8'hFF);
    for (k = 0; k < 3; k++) begin
      send_item(OP_RESOLVE, 32'h4000_0000 + $urandom_range(0, 4200), $urandom,
                2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                8'($urandom_range(0, 255)));
    end
    send_item(OP_UNUSED, '0, '0, 2'd0, 2'd0, 8'd0);
    send_item(OP_CLEAR, '0, '0, 2'd0, 2'd0, 8'd0);
    send_item(OP_RESOLVE, 32'h4000_0000, '0, 2'd0, 2'd0, 8'd0);
  endtask

  // Sessions: clear, load a small clustered table, resolve near its entries;
  // some sessions skip the clear, and noise items are mixed in.
  task automatic test_random_sessions;
    int unsigned sent;
    int unsigned n_load;
    int unsigned n_query;
    int unsigned k;
    int unsigned j;
    logic [1:0]  op;
    logic [31:0] base;
    logic [31:0] start;
    logic [31:0] span;
    logic [31:0] off;
    logic [31:0] q;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent == 0 || $urandom_range(0, 11) == 0) wait_for_results();
      if (sym_count > 200 || $urandom_range(0, 9) != 0) begin
        send_item(OP_CLEAR, $urandom, $urandom, 2'($urandom_range(0, 3)),
                  2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        sent++;
      end
      case ($urandom_range(0, 3))
        0:       base = $urandom_range(0, 255);
        1:       base = 32'hFFFF_FC00 + $urandom_range(0, 1023);
        default: base = $urandom;
      endcase
      n_load = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 48) : $urandom_range(1, 12);
      for (k = 0; k < n_load; k++) begin
        if (sym_count > 0 && $urandom_range(0, 3) == 0) begin
          start = sym_table[$urandom_range(0, sym_count - 1)].start;  // tie
        end else if ($urandom_range(0, 15) == 0) begin
          start = $urandom;
        end else begin
          start = base + $urandom_range(0, 1023);
        end
        case ($urandom_range(0, 5))
          0:       span = 32'd0;
          1:       span = $urandom_range(1, 64);
          2:       span = $urandom_range(1, 1024);
          3:       span = $urandom;
          4:       span = 32'hFFFF_FFFF;
          default: span = $urandom_range(1, 16);
        endcase
        send_item(OP_LOAD, start, span, 2'($urandom_range(0, 3)),
                  2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        sent++;
      end
      n_query = $urandom_range(2, 10);
      for (k = 0; k < n_query; k++) begin
        if (sym_count == 0) begin
          q = $urandom;
        end else begin
          j = $urandom_range(0, sym_count - 1);
          start = sym_table[j].start;
          span = sym_table[j].span;
          case ($urandom_range(0, 6))
            0:       off = 32'd0;
            1:       off = span - 1;
            2:       off = span;
            3:       off = (span == 0) ? 32'd0 : $urandom_range(0, span - 1);
            4:       off = $urandom_range(0, 16);
            5:       off = -$urandom_range(1, 8);  // just below the start
            default: off = $urandom - start;       // anywhere
          endcase
          q = start + off;
        end
        send_item(OP_RESOLVE, q, $urandom, 2'($urandom_range(0, 3)),
                  2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        sent++;
      end
      // Noise: any op, fully random fields.
      for (k = $urandom_range(0, 2); k > 0; k--) begin
        op = 2'($urandom_range(0, 3));
        send_item(op, $urandom, $urandom, 2'($urandom_range(0, 3)),
                  2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        if (op != OP_UNUSED) sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_table();
    test_cover_rules();
    test_tie_break();
    test_table_full();
    test_random_sessions();
    s_axis_tvalid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && results_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
